### hw/rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants of the roaming controller
// Request and response payload structs, motion and scan codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

   // Motion commands
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_FWD  = 2'd1;
   localparam logic [1:0] CMD_BACK = 2'd2;
   localparam logic [1:0] CMD_TURN = 2'd3;

   // Front scan verdicts (any other code counts as incomplete)
   localparam logic [1:0] SCAN_CLEAR      = 2'd0;
   localparam logic [1:0] SCAN_OBSTACLE   = 2'd1;
   localparam logic [1:0] SCAN_INCOMPLETE = 2'd2;

   // Mode codes as reported on the response
   localparam logic [2:0] MODE_CODE_WAIT  = 3'd0;
   localparam logic [2:0] MODE_CODE_FWD   = 3'd1;
   localparam logic [2:0] MODE_CODE_CORR  = 3'd2;
   localparam logic [2:0] MODE_CODE_BACK  = 3'd3;
   localparam logic [2:0] MODE_CODE_AVOID = 3'd4;

   // Request function codes
   localparam logic FUNC_BEGIN  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_PAUSE     = 3'd0;
   localparam logic [2:0] REG_LOSS      = 3'd1;
   localparam logic [2:0] REG_CHANCE    = 3'd2;
   localparam logic [2:0] REG_FWD_MIN   = 3'd3;
   localparam logic [2:0] REG_FWD_MAX   = 3'd4;
   localparam logic [2:0] REG_AVOID_MIN = 3'd5;
   localparam logic [2:0] REG_AVOID_MAX = 3'd6;
   localparam logic [2:0] REG_BACKUP    = 3'd7;

   // Register reset values
   localparam logic [15:0] RST_PAUSE     = 16'd1000;
   localparam logic [15:0] RST_LOSS      = 16'd500;
   localparam logic [6:0]  RST_CHANCE    = 7'd30;
   localparam logic [14:0] RST_FWD_MIN   = 15'd200;
   localparam logic [14:0] RST_FWD_MAX   = 15'd1000;
   localparam logic [11:0] RST_AVOID_MIN = 12'd900;
   localparam logic [11:0] RST_AVOID_MAX = 12'd1800;
   localparam logic [14:0] RST_BACKUP    = 15'd200;

   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic [1:0]  front_scan;
      logic        motor_busy;
      logic [6:0]  rand_percent;
      logic [15:0] rand_fraction;
      logic        rand_sign;
   } req_type;

   typedef struct packed {
      logic               stop_motor;
      logic [1:0]         motion_cmd;
      logic signed [15:0] motion_amount;
      logic               sweep_start;
      logic               look_center;
      logic [2:0]         mode_out;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/explore_roaming_controller_top.sv
// ----------------------------------------------------------------------------
// explore_roaming_controller_top: roaming controller for a small vehicle
// Wait / drive / back away / turn / correct sequencing from timed scan ticks.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_* is one tick: a begin or an update, with the current
//   millisecond time, the front scan verdict, motor busy and random draws.
//   Each request yields exactly one response on rsp_* carrying the motion
//   command, scanner actions and the mode after the tick.
//   The request lands in an input register, then one pass of compare logic
//   and a single 16x17 multiplier (the range draw) fills the response
//   register, which drives rsp_valid.
//   Throughput is one request per cycle while rsp_stall is low; the input
//   register can still take one while a finished response waits to be taken.
//   When rsp_stall is high the response holds; once both the input and the
//   response registers are full, req_stall rises until the receiver drains.
//   Configuration registers sit on an APB-style port at byte address 4*index
//   and must be written only while the block is idle (user rule, unchecked).
//   Reset (synchronous, active high) empties both registers, returns the mode
//   to waiting, clears the timing state and reloads every register's default.
// ----------------------------------------------------------------------------
`default_nettype none

module explore_roaming_controller_top #(
   parameter int CORRECTION_MIN_TENTH_DEG = 50,
   parameter int CORRECTION_MAX_TENTH_DEG = 200
) (
   input  wire               clock,
   input  wire               reset,

   input  wire               req_valid,
   output logic              req_stall,
   input  erc_pkg::req_type  req_data,

   output logic              rsp_valid,
   input  wire               rsp_stall,
   output erc_pkg::rsp_type  rsp_data,

   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [4:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef enum logic [2:0] {
      MODE_WAIT  = 3'd0,
      MODE_FWD   = 3'd1,
      MODE_CORR  = 3'd2,
      MODE_BACK  = 3'd3,
      MODE_AVOID = 3'd4
   } mode_type;

   localparam logic [14:0] CORR_LO = 15'(CORRECTION_MIN_TENTH_DEG);
   localparam logic [14:0] CORR_HI = 15'(CORRECTION_MAX_TENTH_DEG);

   // Configuration registers
   logic [15:0] pause_ff;
   logic [15:0] loss_ff;
   logic [6:0]  chance_ff;
   logic [14:0] fwd_min_ff;
   logic [14:0] fwd_max_ff;
   logic [11:0] avoid_min_ff;
   logic [11:0] avoid_max_ff;
   logic [14:0] backup_ff;

   // Controller state
   mode_type    mode_ff, mode_in;
   logic [31:0] wait_start_ff, wait_start_in;
   logic        lost_ff, lost_in;
   logic [31:0] lost_start_ff, lost_start_in;

   // Pipeline registers
   logic             in_valid_ff;
   erc_pkg::req_type in_ff;
   logic             out_valid_ff;
   erc_pkg::rsp_type out_ff, out_in;

   logic        cfg_wr;
   logic [2:0]  cfg_idx;
   logic        out_free;
   logic        fire;
   logic        in_load;

   logic [14:0]        draw_lo;
   logic [14:0]        draw_hi;
   logic signed [15:0] draw_diff;
   logic signed [32:0] draw_prod;
   logic signed [16:0] draw_val;
   logic [15:0]        draw_mag;
   logic [15:0]        turn_amt;
   logic [31:0]        wait_elapsed;
   logic [31:0]        lost_elapsed;
   logic               fwd_done;

   // --------------------------------------------------------------------
   // Configuration port
   // --------------------------------------------------------------------
   assign pready  = 1'b1;
   assign cfg_idx = paddr[4:2];
   assign cfg_wr  = psel & penable & pwrite & pready;

   always_comb begin
      case (cfg_idx)
         erc_pkg::REG_PAUSE:     prdata = {16'd0, pause_ff};
         erc_pkg::REG_LOSS:      prdata = {16'd0, loss_ff};
         erc_pkg::REG_CHANCE:    prdata = {25'd0, chance_ff};
         erc_pkg::REG_FWD_MIN:   prdata = {17'd0, fwd_min_ff};
         erc_pkg::REG_FWD_MAX:   prdata = {17'd0, fwd_max_ff};
         erc_pkg::REG_AVOID_MIN: prdata = {20'd0, avoid_min_ff};
         erc_pkg::REG_AVOID_MAX: prdata = {20'd0, avoid_max_ff};
         erc_pkg::REG_BACKUP:    prdata = {17'd0, backup_ff};
         default:                prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff     <= erc_pkg::RST_PAUSE;
         loss_ff      <= erc_pkg::RST_LOSS;
         chance_ff    <= erc_pkg::RST_CHANCE;
         fwd_min_ff   <= erc_pkg::RST_FWD_MIN;
         fwd_max_ff   <= erc_pkg::RST_FWD_MAX;
         avoid_min_ff <= erc_pkg::RST_AVOID_MIN;
         avoid_max_ff <= erc_pkg::RST_AVOID_MAX;
         backup_ff    <= erc_pkg::RST_BACKUP;
      end else if (cfg_wr) begin
         case (cfg_idx)
            erc_pkg::REG_PAUSE:     pause_ff     <= pwdata[15:0];
            erc_pkg::REG_LOSS:      loss_ff      <= pwdata[15:0];
            erc_pkg::REG_CHANCE:    chance_ff    <= pwdata[6:0];
            erc_pkg::REG_FWD_MIN:   fwd_min_ff   <= pwdata[14:0];
            erc_pkg::REG_FWD_MAX:   fwd_max_ff   <= pwdata[14:0];
            erc_pkg::REG_AVOID_MIN: avoid_min_ff <= pwdata[11:0];
            erc_pkg::REG_AVOID_MAX: avoid_max_ff <= pwdata[11:0];
            erc_pkg::REG_BACKUP:    backup_ff    <= pwdata[14:0];
            default:                pause_ff     <= pause_ff;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // Handshake: input register feeds the response register
   // --------------------------------------------------------------------
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign in_load   = req_valid & ~req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // --------------------------------------------------------------------
   // Range draw: lo + floor((hi - lo) * f / 2^16), one shared multiplier
   // --------------------------------------------------------------------
   always_comb begin
      case (mode_ff)
         MODE_WAIT: begin
            draw_lo = fwd_min_ff;
            draw_hi = fwd_max_ff;
         end
         MODE_BACK: begin
            draw_lo = {3'd0, avoid_min_ff};
            draw_hi = {3'd0, avoid_max_ff};
         end
         default: begin
            draw_lo = CORR_LO;
            draw_hi = CORR_HI;
         end
      endcase
   end

   assign draw_diff = $signed({1'b0, draw_hi}) - $signed({1'b0, draw_lo});
   assign draw_prod = draw_diff * $signed({1'b0, in_ff.rand_fraction});
   assign draw_val  = $signed({2'b00, draw_lo}) + draw_prod[32:16];
   assign draw_mag  = draw_val[15:0];
   assign turn_amt  = in_ff.rand_sign ? draw_mag : (16'd0 - draw_mag);

   // Wrapping elapsed times
   assign wait_elapsed = in_ff.now_ms - wait_start_ff;
   assign lost_elapsed = in_ff.now_ms - lost_start_ff;

   // --------------------------------------------------------------------
   // Next mode, timing state and response for the item in the input register
   // --------------------------------------------------------------------
   always_comb begin
      mode_in       = mode_ff;
      wait_start_in = wait_start_ff;
      lost_in       = lost_ff;
      lost_start_in = lost_start_ff;
      fwd_done      = 1'b0;

      out_in               = '0;
      out_in.motion_cmd    = erc_pkg::CMD_NONE;

      if (in_ff.func == erc_pkg::FUNC_BEGIN) begin
         // stop and restart the pause
         out_in.stop_motor  = 1'b1;
         out_in.sweep_start = 1'b1;
         mode_in            = MODE_WAIT;
         wait_start_in      = in_ff.now_ms;
      end else begin
         case (mode_ff)
            MODE_WAIT: begin
               if (wait_elapsed >= {16'd0, pause_ff}) begin
                  if (in_ff.front_scan == erc_pkg::SCAN_CLEAR) begin
                     mode_in              = MODE_FWD;
                     lost_in              = 1'b0;
                     out_in.motion_cmd    = erc_pkg::CMD_FWD;
                     out_in.motion_amount = draw_mag;
                  end else if (in_ff.front_scan == erc_pkg::SCAN_OBSTACLE) begin
                     out_in.stop_motor    = 1'b1;
                     out_in.look_center   = 1'b1;
                     mode_in              = MODE_BACK;
                     out_in.motion_cmd    = erc_pkg::CMD_BACK;
                     out_in.motion_amount = {1'b0, backup_ff};
                  end
               end
            end
            MODE_FWD: begin
               if (in_ff.front_scan == erc_pkg::SCAN_OBSTACLE) begin
                  out_in.stop_motor    = 1'b1;
                  out_in.look_center   = 1'b1;
                  mode_in              = MODE_BACK;
                  out_in.motion_cmd    = erc_pkg::CMD_BACK;
                  out_in.motion_amount = {1'b0, backup_ff};
                  fwd_done             = 1'b1;
               end else if (in_ff.front_scan == erc_pkg::SCAN_CLEAR) begin
                  lost_in = 1'b0;
               end else if (!lost_ff) begin
                  // first incomplete scan: start the loss timer
                  lost_in       = 1'b1;
                  lost_start_in = in_ff.now_ms;
               end else if (lost_elapsed >= {16'd0, loss_ff}) begin
                  out_in.stop_motor  = 1'b1;
                  out_in.sweep_start = 1'b1;
                  mode_in            = MODE_WAIT;
                  wait_start_in      = in_ff.now_ms;
                  fwd_done           = 1'b1;
               end

               // drive finished: maybe correct course, else wait
               if (!fwd_done && !in_ff.motor_busy) begin
                  if (in_ff.rand_percent < chance_ff) begin
                     out_in.look_center   = 1'b1;
                     mode_in              = MODE_CORR;
                     out_in.motion_cmd    = erc_pkg::CMD_TURN;
                     out_in.motion_amount = turn_amt;
                  end else begin
                     out_in.sweep_start = 1'b1;
                     mode_in            = MODE_WAIT;
                     wait_start_in      = in_ff.now_ms;
                  end
               end
            end
            MODE_CORR, MODE_AVOID: begin
               if (!in_ff.motor_busy) begin
                  out_in.sweep_start = 1'b1;
                  mode_in            = MODE_WAIT;
                  wait_start_in      = in_ff.now_ms;
               end
            end
            MODE_BACK: begin
               if (!in_ff.motor_busy) begin
                  mode_in              = MODE_AVOID;
                  out_in.motion_cmd    = erc_pkg::CMD_TURN;
                  out_in.motion_amount = turn_amt;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end

      out_in.mode_out = mode_in;
   end

   // --------------------------------------------------------------------
   // Registers: pipeline control, state and payload
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_WAIT;
         wait_start_ff <= 32'd0;
         lost_ff       <= 1'b0;
         lost_start_ff <= 32'd0;
      end else begin
         in_valid_ff  <= in_load | (in_valid_ff & ~fire);
         out_valid_ff <= fire | (out_valid_ff & rsp_stall);
         if (fire) begin
            mode_ff       <= mode_in;
            wait_start_ff <= wait_start_in;
            lost_ff       <= lost_in;
            lost_start_ff <= lost_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff <= req_data;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   a_no_cmd_no_amount: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.motion_cmd == erc_pkg::CMD_NONE)
      |-> (rsp_data.motion_amount == 16'sd0))
      else $error("amount nonzero without a motion command");

   a_sweep_means_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sweep_start
      |-> (rsp_data.mode_out == erc_pkg::MODE_CODE_WAIT))
      else $error("sweep start outside waiting mode");

   a_back_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.motion_cmd == erc_pkg::CMD_BACK)
      |-> (rsp_data.mode_out == erc_pkg::MODE_CODE_BACK) && rsp_data.look_center
          && rsp_data.stop_motor)
      else $error("backward command without backing entry actions");

   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("held request did not produce a response");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the roaming controller
// Drives tick requests through the valid/stall channel, plans the motion of
// every accepted request with its own copy of the mode and timing state, and
// compares each response field by field. Covers a directed tour of all modes,
// register extremes, a long receiver hold-off and random roaming sessions.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CORR_MIN_TENTH_DEG = 50;
   localparam int CORR_MAX_TENTH_DEG = 200;
   localparam int HOLD_CYCLES        = 300;
   localparam int QUIET_LIMIT        = 4000;
   localparam logic [1:0] SCAN_UNDEFINED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   erc_pkg::req_type  req_data = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   erc_pkg::rsp_type  rsp_data;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Planned state of the controller and its register copy
   logic [2:0]  roam_mode = erc_pkg::MODE_CODE_WAIT;
   logic [31:0] wait_since_ms = '0;
   logic        scan_lost = 1'b0;
   logic [31:0] lost_since_ms = '0;
   logic [31:0] setting [8];

   erc_pkg::rsp_type planned_motion [$];
   erc_pkg::rsp_type want_motion;
   int          fault_count = 0;
   int          quiet_cycles = 0;

   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;
   bit          rsp_hold = 1'b0;
   logic [31:0] tick_ms = '0;
   logic [1:0]  roam_scan = erc_pkg::SCAN_CLEAR;

   explore_roaming_controller_top #(
      .CORRECTION_MIN_TENTH_DEG(CORR_MIN_TENTH_DEG),
      .CORRECTION_MAX_TENTH_DEG(CORR_MAX_TENTH_DEG)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Range draw: lo*(1-f) + hi*f with f in 1/65536 steps, rounded down
   function automatic logic [15:0] draw_between(input logic [31:0] lo, input logic [31:0] hi,
                                                input logic [15:0] frac);
      logic [63:0] acc;
      acc = lo * (64'd65536 - frac) + hi * frac;
      return acc[31:16];
   endfunction

   function automatic logic [15:0] turn_by(input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [15:0] frac, input logic keep_sign);
      logic [15:0] mag;
      mag = draw_between(lo, hi, frac);
      return keep_sign ? mag : -mag;
   endfunction

   function automatic logic [31:0] field_mask(input logic [2:0] idx);
      case (idx)
         erc_pkg::REG_PAUSE, erc_pkg::REG_LOSS:         return 32'hFFFF;
         erc_pkg::REG_CHANCE:                           return 32'h7F;
         erc_pkg::REG_AVOID_MIN, erc_pkg::REG_AVOID_MAX: return 32'hFFF;
         default:                                       return 32'h7FFF;
      endcase
   endfunction

   // Plan the response of one tick and advance the planned state
   function automatic erc_pkg::rsp_type plan_motion(input erc_pkg::req_type r);
      erc_pkg::rsp_type o;
      logic [31:0]      waited;
      logic             done;
      o = '0;
      done = 1'b0;
      waited = r.now_ms - wait_since_ms;
      if (r.func == erc_pkg::FUNC_BEGIN) begin
         o.stop_motor = 1'b1;
         o.sweep_start = 1'b1;
         roam_mode = erc_pkg::MODE_CODE_WAIT;
         wait_since_ms = r.now_ms;
      end else begin
         case (roam_mode)
            erc_pkg::MODE_CODE_WAIT: begin
               if (waited >= setting[erc_pkg::REG_PAUSE]) begin
                  if (r.front_scan == erc_pkg::SCAN_CLEAR) begin
                     roam_mode = erc_pkg::MODE_CODE_FWD;
                     scan_lost = 1'b0;
                     o.motion_cmd = erc_pkg::CMD_FWD;
                     o.motion_amount = draw_between(setting[erc_pkg::REG_FWD_MIN],
                                                    setting[erc_pkg::REG_FWD_MAX],
                                                    r.rand_fraction);
                  end else if (r.front_scan == erc_pkg::SCAN_OBSTACLE) begin
                     o.stop_motor = 1'b1;
                     o.look_center = 1'b1;
                     roam_mode = erc_pkg::MODE_CODE_BACK;
                     o.motion_cmd = erc_pkg::CMD_BACK;
                     o.motion_amount = setting[erc_pkg::REG_BACKUP][15:0];
                  end
               end
            end
            erc_pkg::MODE_CODE_FWD: begin
               if (r.front_scan == erc_pkg::SCAN_OBSTACLE) begin
                  o.stop_motor = 1'b1;
                  o.look_center = 1'b1;
                  roam_mode = erc_pkg::MODE_CODE_BACK;
                  o.motion_cmd = erc_pkg::CMD_BACK;
                  o.motion_amount = setting[erc_pkg::REG_BACKUP][15:0];
                  done = 1'b1;
               end else if (r.front_scan == erc_pkg::SCAN_CLEAR) begin
                  scan_lost = 1'b0;
               end else if (!scan_lost) begin
                  scan_lost = 1'b1;
                  lost_since_ms = r.now_ms;
               end else if (r.now_ms - lost_since_ms >= setting[erc_pkg::REG_LOSS]) begin
                  // scans lost for too long: stop and wait
                  o.stop_motor = 1'b1;
                  o.sweep_start = 1'b1;
                  roam_mode = erc_pkg::MODE_CODE_WAIT;
                  wait_since_ms = r.now_ms;
                  done = 1'b1;
               end
               // drive finished: maybe a course correction
               if (!done && !r.motor_busy) begin
                  if (r.rand_percent < setting[erc_pkg::REG_CHANCE]) begin
                     o.look_center = 1'b1;
                     roam_mode = erc_pkg::MODE_CODE_CORR;
                     o.motion_cmd = erc_pkg::CMD_TURN;
                     o.motion_amount = turn_by(CORR_MIN_TENTH_DEG, CORR_MAX_TENTH_DEG,
                                               r.rand_fraction, r.rand_sign);
                  end else begin
                     o.sweep_start = 1'b1;
                     roam_mode = erc_pkg::MODE_CODE_WAIT;
                     wait_since_ms = r.now_ms;
                  end
               end
            end
            erc_pkg::MODE_CODE_CORR, erc_pkg::MODE_CODE_AVOID: begin
               if (!r.motor_busy) begin
                  o.sweep_start = 1'b1;
                  roam_mode = erc_pkg::MODE_CODE_WAIT;
                  wait_since_ms = r.now_ms;
               end
            end
            erc_pkg::MODE_CODE_BACK: begin
               if (!r.motor_busy) begin
                  roam_mode = erc_pkg::MODE_CODE_AVOID;
                  o.motion_cmd = erc_pkg::CMD_TURN;
                  o.motion_amount = turn_by(setting[erc_pkg::REG_AVOID_MIN],
                                            setting[erc_pkg::REG_AVOID_MAX],
                                            r.rand_fraction, r.rand_sign);
               end
            end
            default: ;
         endcase
      end
      o.mode_out = roam_mode;
      return o;
   endfunction

   // Plan each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         planned_motion.push_back(plan_motion(req_data));
   end

   // Compare each accepted response with the oldest plan
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (planned_motion.size() == 0) begin
            $error("response with no request waiting");
            fault_count++;
         end else begin
            want_motion = planned_motion.pop_front();
            if (rsp_data.stop_motor !== want_motion.stop_motor) begin
               $error("stop_motor: expected %0d, got %0d",
                      want_motion.stop_motor, rsp_data.stop_motor);
               fault_count++;
            end
            if (rsp_data.motion_cmd !== want_motion.motion_cmd) begin
               $error("motion_cmd: expected %0d, got %0d",
                      want_motion.motion_cmd, rsp_data.motion_cmd);
               fault_count++;
            end
            if (rsp_data.motion_amount !== want_motion.motion_amount) begin
               $error("motion_amount: expected %0d, got %0d",
                      want_motion.motion_amount, rsp_data.motion_amount);
               fault_count++;
            end
            if (rsp_data.sweep_start !== want_motion.sweep_start) begin
               $error("sweep_start: expected %0d, got %0d",
                      want_motion.sweep_start, rsp_data.sweep_start);
               fault_count++;
            end
            if (rsp_data.look_center !== want_motion.look_center) begin
               $error("look_center: expected %0d, got %0d",
                      want_motion.look_center, rsp_data.look_center);
               fault_count++;
            end
            if (rsp_data.mode_out !== want_motion.mode_out) begin
               $error("mode_out: expected %0d, got %0d",
                      want_motion.mode_out, rsp_data.mode_out);
               fault_count++;
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Receiver pacing: random stall bursts, or one long counted hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            rsp_hold = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request, with an optional gap, and hold it until accepted
   task automatic send_request(input erc_pkg::req_type item);
      if (req_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic tick(input logic func, input logic [31:0] now, input logic [1:0] scan,
                       input logic busy, input logic [6:0] pct, input logic [15:0] frac,
                       input logic keep_sign);
      erc_pkg::req_type r;
      r.func = func;
      r.now_ms = now;
      r.front_scan = scan;
      r.motor_busy = busy;
      r.rand_percent = pct;
      r.rand_fraction = frac;
      r.rand_sign = keep_sign;
      send_request(r);
   endtask

   // Drop valid and wait until every planned response has come
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (planned_motion.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register (junk above its width), then read it back
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] word;
      mask = field_mask(idx);
      word = ($urandom & ~mask) | (value & mask);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      setting[idx] = word & mask;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== setting[idx]) begin
         $error("register %0d: expected %0h, got %0h", idx, setting[idx], prdata);
         fault_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] pause, input logic [31:0] loss,
                                 input logic [31:0] chance, input logic [31:0] fwd_min,
                                 input logic [31:0] fwd_max, input logic [31:0] avoid_min,
                                 input logic [31:0] avoid_max, input logic [31:0] backup);
      settle();
      csr_write(erc_pkg::REG_PAUSE, pause);
      csr_write(erc_pkg::REG_LOSS, loss);
      csr_write(erc_pkg::REG_CHANCE, chance);
      csr_write(erc_pkg::REG_FWD_MIN, fwd_min);
      csr_write(erc_pkg::REG_FWD_MAX, fwd_max);
      csr_write(erc_pkg::REG_AVOID_MIN, avoid_min);
      csr_write(erc_pkg::REG_AVOID_MAX, avoid_max);
      csr_write(erc_pkg::REG_BACKUP, backup);
   endtask

   // Random roaming: mostly ordered update ticks with sticky scan verdicts,
   // some begin requests and a little noise with arbitrary time
   task automatic roam(input int count, input int unsigned step_max);
      erc_pkg::req_type r;
      int               roll;
      for (int i = 0; i < count; i++) begin
         r.rand_percent = 7'($urandom_range(0, 127));
         r.rand_fraction = 16'($urandom);
         r.rand_sign = 1'($urandom);
         r.motor_busy = ($urandom_range(0, 9) < 6);
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            r.func = 1'($urandom);
            r.now_ms = $urandom;
            r.front_scan = 2'($urandom);
            r.motor_busy = 1'($urandom);
         end else begin
            if ($urandom_range(0, 49) == 0)
               tick_ms = tick_ms + $urandom;
            else
               tick_ms = tick_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 9) < 3)
               roam_scan = 2'($urandom);
            r.func = (roll < 5) ? erc_pkg::FUNC_BEGIN : erc_pkg::FUNC_UPDATE;
            r.now_ms = tick_ms;
            r.front_scan = roam_scan;
         end
         send_request(r);
      end
   endtask

   // Walk every mode and transition with the reset settings
   task automatic check_directed_sequence();
      tick(erc_pkg::FUNC_UPDATE, 500, erc_pkg::SCAN_CLEAR, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1000, erc_pkg::SCAN_CLEAR, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1050, erc_pkg::SCAN_CLEAR, 1'b1, 127, 16'hFFFF, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1100, erc_pkg::SCAN_INCOMPLETE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1200, erc_pkg::SCAN_CLEAR, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1300, erc_pkg::SCAN_INCOMPLETE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1799, SCAN_UNDEFINED, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 1800, erc_pkg::SCAN_INCOMPLETE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_BEGIN, 2000, erc_pkg::SCAN_OBSTACLE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 3000, erc_pkg::SCAN_CLEAR, 1'b1, 0, 16'hFFFF, 1'b0);
      tick(erc_pkg::FUNC_UPDATE, 3050, erc_pkg::SCAN_CLEAR, 1'b0, 29, 16'hFFFF, 1'b0);
      tick(erc_pkg::FUNC_UPDATE, 3060, erc_pkg::SCAN_CLEAR, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 3070, erc_pkg::SCAN_CLEAR, 1'b0, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 4070, erc_pkg::SCAN_OBSTACLE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 4080, erc_pkg::SCAN_OBSTACLE, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 4090, erc_pkg::SCAN_CLEAR, 1'b0, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 4100, erc_pkg::SCAN_CLEAR, 1'b0, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 5100, erc_pkg::SCAN_CLEAR, 1'b1, 0, 16'h8000, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 5110, erc_pkg::SCAN_OBSTACLE, 1'b0, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 5120, erc_pkg::SCAN_OBSTACLE, 1'b0, 0, 16'hFFFF, 1'b0);
      // time wraps: one short of the pause, then exactly the pause
      tick(erc_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, erc_pkg::SCAN_CLEAR, 1'b0, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 32'h0000_03D7, erc_pkg::SCAN_CLEAR, 1'b1, 0, 0, 1'b1);
      tick(erc_pkg::FUNC_UPDATE, 32'h0000_03D8, erc_pkg::SCAN_CLEAR, 1'b0, 30, 16'h5555,
           1'b1);
      tick(erc_pkg::FUNC_UPDATE, 32'h0000_03E0, erc_pkg::SCAN_INCOMPLETE, 1'b0, 30,
           16'hAAAA, 1'b0);
      tick(erc_pkg::FUNC_BEGIN, 32'hFFFF_FFFF, SCAN_UNDEFINED, 1'b0, 127, 16'hFFFF, 1'b0);
   endtask

   // Zero and all-ones settings, with equal draw bounds
   task automatic check_register_extremes();
      tick_ms = $urandom;
      apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
      roam(60, 5);
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      roam(60, 40000);
   endtask

   // Hold the receiver off while requests keep coming, then drain fully
   task automatic check_backpressure();
      apply_settings(0, 20, 50, 100, 900, 450, 1350, 120);
      req_idling = 1'b0;
      rsp_hold = 1'b1;
      roam(30, 30);
      settle();
      req_idling = 1'b1;
   endtask

   task automatic check_random_roaming();
      apply_settings(100, 60, 30, 200, 1000, 900, 1800, 200);
      roam(230, 80);
      apply_settings(0, 0, 100, 30000, 5, 4095, 0, 32767);
      roam(180, 10);
      apply_settings(65535, 65535, 0, 0, 32767, 0, 3600, 0);
      roam(140, 40000);
      apply_settings($urandom_range(0, 400), $urandom_range(0, 300), $urandom_range(0, 127),
                     $urandom_range(0, 32767), $urandom_range(0, 32767),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 32767));
      roam(180, 150);
      // last part runs without idling on either side
      apply_settings(50, 40, 60, 100, 3000, 300, 2700, 150);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      roam(180, 60);
   endtask

   initial begin
      setting[erc_pkg::REG_PAUSE] = erc_pkg::RST_PAUSE;
      setting[erc_pkg::REG_LOSS] = erc_pkg::RST_LOSS;
      setting[erc_pkg::REG_CHANCE] = erc_pkg::RST_CHANCE;
      setting[erc_pkg::REG_FWD_MIN] = erc_pkg::RST_FWD_MIN;
      setting[erc_pkg::REG_FWD_MAX] = erc_pkg::RST_FWD_MAX;
      setting[erc_pkg::REG_AVOID_MIN] = erc_pkg::RST_AVOID_MIN;
      setting[erc_pkg::REG_AVOID_MAX] = erc_pkg::RST_AVOID_MAX;
      setting[erc_pkg::REG_BACKUP] = erc_pkg::RST_BACKUP;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_directed_sequence();
      check_register_extremes();
      check_backpressure();
      check_random_roaming();
      settle();
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### explore_roaming_controller_top.f
hw/rtl/erc_pkg.sv
hw/rtl/explore_roaming_controller_top.sv
tb/sv/tb_top.sv
